// File: sv/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared widths, register codes and controller/datapath interface types of
// the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  // Sample format and sizing
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned MAX_UPSAMPLE = 4;

  localparam int unsigned RATE_W    = 18;               // rate registers
  localparam int unsigned CNT_CFG_W = 4;                // channel count register
  localparam int unsigned CHAN_W    = 3;                // channel index
  localparam int unsigned PHASE_W   = 19;               // phase remainder
  localparam int unsigned WALK_W    = PHASE_W + 1;      // phase walker headroom
  localparam int unsigned DIFF_W    = SAMPLE_BITS + 1;  // sample difference
  localparam int unsigned PROD_W    = DIFF_W + PHASE_W + 1;
  localparam int unsigned DIV_W     = 34;               // |diff * phase| bound
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned UPS_W     = 3;                // holds 0..MAX_UPSAMPLE
  localparam int unsigned TOT_W     = 4;                // holds 0..2*MAX_UPSAMPLE
  localparam int unsigned FRM_W     = 3;                // output frame index
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RATE_W-1:0]    RESET_RATE     = RATE_W'(48000);
  localparam logic [CNT_CFG_W-1:0] RESET_CHANNELS = CNT_CFG_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_RATE   = 2'd0,
    CFG_TARGET_RATE   = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_sample;
    logic step_init;
    logic walk_step;
    logic span1_close;
    logic mod_close;
    logic span2_close;
    logic emit_init;
    logic mul_load;
    logic div_start;
    logic div_sel_mod;
    logic out_load;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_done;
    logic have_prev;
    logic final_step;
    logic walk_go;
    logic walk_below;
    logic div_done;
    logic total_zero;
    logic is_tail;
    logic is_last;
    logic out_free;
  } stat_t;

endpackage

// File: sv/linear_interp_resampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Streaming linear-interpolation sample rate converter for interleaved Q1.15
// audio, with configuration registers.
// ----------------------------------------------------------------------------
// Samples enter one per cycle while a frame is being collected; the frame's
// last sample starts a step that takes no further input until it ends. A step
// first walks the phase over each span (S_TAIL lies between the two spans and
// S_ESET before the outputs), with one serial division when outputs must be
// dropped above 4x upsampling, then emits its output samples one by one: an
// interpolated sample passes through the multiplier and the one-bit-per-cycle
// divider, and a tail sample (copy of the last frame) goes straight to the
// output, each waiting longer while the output stalls. A step closes in a
// final state. The output register lets the next input be taken while the
// last result waits.
// A rate written as zero acts as one; a channel count of zero acts as one and
// one above eight as eight. Write configuration only between regions.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lirs_pkg::RATE_W-1:0]           cfg_data_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                  final_frame_i,
  // output items
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [lirs_pkg::CHAN_W-1:0]           channel_index_o,
  output logic                                  run_last_o,
  output logic                                  region_last_o,
  output logic                                  overrun_o
);

  logic [lirs_pkg::RATE_W-1:0]    src_rate_q;
  logic [lirs_pkg::RATE_W-1:0]    dst_rate_q;
  logic [lirs_pkg::CNT_CFG_W-1:0] ch_count_q;
  logic [lirs_pkg::RATE_W-1:0]    src_eff;
  logic [lirs_pkg::RATE_W-1:0]    dst_eff;
  logic [lirs_pkg::CNT_CFG_W-1:0] ch_eff;
  lirs_pkg::cmd_t                 cmd;
  lirs_pkg::stat_t                stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q <= lirs_pkg::RESET_RATE;
      dst_rate_q <= lirs_pkg::RESET_RATE;
      ch_count_q <= lirs_pkg::RESET_CHANNELS;
    end else if (cfg_we_i) begin
      case (lirs_pkg::cfg_reg_e'(cfg_index_i))
        lirs_pkg::CFG_SOURCE_RATE:   src_rate_q <= cfg_data_i;
        lirs_pkg::CFG_TARGET_RATE:   dst_rate_q <= cfg_data_i;
        lirs_pkg::CFG_CHANNEL_COUNT: ch_count_q <= cfg_data_i[lirs_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range settings
  assign src_eff = (src_rate_q == '0) ? lirs_pkg::RATE_W'(1) : src_rate_q;
  assign dst_eff = (dst_rate_q == '0) ? lirs_pkg::RATE_W'(1) : dst_rate_q;
  always_comb begin
    if (ch_count_q == '0) begin
      ch_eff = lirs_pkg::CNT_CFG_W'(1);
    end else if (ch_count_q > lirs_pkg::CNT_CFG_W'(lirs_pkg::MAX_CHANNELS)) begin
      ch_eff = lirs_pkg::CNT_CFG_W'(lirs_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = ch_count_q;
    end
  end

  lirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lirs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_in_i     (sample_in_i),
    .final_frame_i   (final_frame_i),
    .src_i           (src_eff),
    .dst_i           (dst_eff),
    .ch_i            (ch_eff),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .sample_out_o    (sample_out_o),
    .channel_index_o (channel_index_o),
    .run_last_o      (run_last_o),
    .region_last_o   (region_last_o),
    .overrun_o       (overrun_o)
  );

endmodule

// File: sv/lirs_div.sv
// ----------------------------------------------------------------------------
// lirs_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient and
// remainder; done stays high until the next start.
// ----------------------------------------------------------------------------
module lirs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lirs_pkg::DIV_W-1:0]        num_i,
  input  logic [lirs_pkg::RATE_W-1:0]       den_i,
  output logic                              done_o,
  output logic [lirs_pkg::DIV_W-1:0]        quot_o,
  output logic [lirs_pkg::RATE_W-1:0]       rem_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [lirs_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [lirs_pkg::DIV_W-1:0]        num_q;
  logic [lirs_pkg::RATE_W-1:0]       rem_q;
  logic [lirs_pkg::RATE_W-1:0]       den_q;
  logic [lirs_pkg::RATE_W:0]         trial;
  logic [lirs_pkg::RATE_W:0]         trial_sub;
  logic                              ge;

  // Shift in the next numerator bit and try the subtraction
  assign trial     = {rem_q, num_q[lirs_pkg::DIV_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= lirs_pkg::DIV_CNT_W'(lirs_pkg::DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[lirs_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? trial_sub[lirs_pkg::RATE_W-1:0] : trial[lirs_pkg::RATE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/lirs_ctrl.sv
// ----------------------------------------------------------------------------
// lirs_ctrl
// Step sequencer: collects samples, walks the phase over the source interval
// and the tail, then emits one output sample at a time.
// ----------------------------------------------------------------------------
module lirs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lirs_pkg::stat_t  stat_i,
  output lirs_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK1,
    S_MOD,
    S_TAIL,
    S_WALK2,
    S_ESET,
    S_PICK,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_OUT,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          if (stat_i.frame_done) begin
            cmd_o.step_init = 1'b1;
            state_d = stat_i.have_prev ? S_WALK1 : S_TAIL;
          end
        end
      end
      S_WALK1: begin
        if (stat_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.span1_close = 1'b1;
          if (stat_i.walk_below) begin
            // skipped outputs: find the phase left over after the skip
            cmd_o.div_start   = 1'b1;
            cmd_o.div_sel_mod = 1'b1;
            state_d = S_MOD;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_MOD: begin
        cmd_o.div_sel_mod = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.mod_close = 1'b1;
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = stat_i.final_step ? S_WALK2 : S_ESET;
      end
      S_WALK2: begin
        if (stat_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.span2_close = 1'b1;
          state_d = S_ESET;
        end
      end
      S_ESET: begin
        if (stat_i.total_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        state_d = stat_i.is_tail ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = stat_i.is_last ? S_FIN : S_PICK;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/lirs_dp.sv
// ----------------------------------------------------------------------------
// lirs_dp
// Datapath: frame store, phase walker, multiplier, shared divider and the
// output register.
// ----------------------------------------------------------------------------
module lirs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lirs_pkg::cmd_t                      cmd_i,
  output lirs_pkg::stat_t                     stat_o,
  input  lirs_pkg::sample_t                   sample_in_i,
  input  logic                                final_frame_i,
  input  logic [lirs_pkg::RATE_W-1:0]         src_i,
  input  logic [lirs_pkg::RATE_W-1:0]         dst_i,
  input  logic [lirs_pkg::CNT_CFG_W-1:0]      ch_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output lirs_pkg::sample_t                   sample_out_o,
  output logic [lirs_pkg::CHAN_W-1:0]         channel_index_o,
  output logic                                run_last_o,
  output logic                                region_last_o,
  output logic                                overrun_o
);

  // Frame store and step state
  lirs_pkg::sample_t                   cur_q  [lirs_pkg::MAX_CHANNELS];
  lirs_pkg::sample_t                   prev_q [lirs_pkg::MAX_CHANNELS];
  logic [lirs_pkg::CHAN_W-1:0]         pos_q;
  logic                                hp_q;
  logic [lirs_pkg::PHASE_W-1:0]        ph_q;
  logic                                final_q;
  logic [lirs_pkg::WALK_W-1:0]         pw_q;
  logic [lirs_pkg::UPS_W-1:0]          cnt_q;
  logic [lirs_pkg::UPS_W-1:0]          n1_q;
  logic [lirs_pkg::UPS_W-1:0]          n2_q;
  logic                                over_q;
  logic [lirs_pkg::FRM_W-1:0]          frame_q;
  logic [lirs_pkg::CHAN_W-1:0]         c_q;
  logic [lirs_pkg::PHASE_W-1:0]        ep_q;
  logic signed [lirs_pkg::PROD_W-1:0]  prod_q;

  // Output register
  logic                                out_valid_q;
  lirs_pkg::sample_t                   out_sample_q;
  logic [lirs_pkg::CHAN_W-1:0]         out_chan_q;
  logic                                out_run_last_q;
  logic                                out_region_last_q;
  logic                                out_overrun_q;

  // Combinational helpers
  logic [lirs_pkg::CHAN_W-1:0]         ch_last;
  logic                                frame_done;
  logic                                below;
  logic [lirs_pkg::TOT_W-1:0]          total;
  logic                                is_tail;
  logic                                is_last;
  logic                                out_free;
  logic signed [lirs_pkg::DIFF_W-1:0]  diff;
  logic [lirs_pkg::PROD_W-1:0]         prod_abs;
  logic [lirs_pkg::WALK_W-1:0]         mod_num;
  logic [lirs_pkg::DIV_W-1:0]          div_num;
  logic [lirs_pkg::RATE_W-1:0]         div_den;
  logic                                div_done;
  logic [lirs_pkg::DIV_W-1:0]          div_quot;
  logic [lirs_pkg::RATE_W-1:0]         div_rem;
  logic signed [lirs_pkg::DIFF_W-1:0]  q_mag;
  logic signed [lirs_pkg::DIFF_W-1:0]  q_floor;
  logic signed [lirs_pkg::DIFF_W-1:0]  interp_sum;
  lirs_pkg::sample_t                   out_value;
  logic [lirs_pkg::CHAN_W-1:0]         c_next;
  logic [lirs_pkg::FRM_W-1:0]          frame_next;
  logic [lirs_pkg::PHASE_W-1:0]        ep_next;

  assign ch_last    = lirs_pkg::CHAN_W'(ch_i - 1'b1);
  assign frame_done = ({1'b0, pos_q} + 1'b1) >= ch_i;
  assign below      = pw_q < {{(lirs_pkg::WALK_W - lirs_pkg::RATE_W){1'b0}}, dst_i};
  assign total      = lirs_pkg::TOT_W'(n1_q) + lirs_pkg::TOT_W'(n2_q);
  assign is_tail    = frame_q >= n1_q;
  assign is_last    = (lirs_pkg::TOT_W'(frame_q) == total - 1'b1) && (c_q == ch_last);
  assign out_free   = !out_valid_q || out_ready_i;

  // Interpolation operands
  assign diff     = lirs_pkg::DIFF_W'(cur_q[c_q]) - lirs_pkg::DIFF_W'(prev_q[c_q]);
  assign prod_abs = prod_q[lirs_pkg::PROD_W-1] ? lirs_pkg::PROD_W'(-prod_q)
                                               : lirs_pkg::PROD_W'(prod_q);

  // Divider operands: leftover phase after a skip, or the interpolation term
  assign mod_num = {{(lirs_pkg::WALK_W - lirs_pkg::RATE_W){1'b0}}, dst_i} - pw_q - 1'b1;
  assign div_num = cmd_i.div_sel_mod
                   ? lirs_pkg::DIV_W'(mod_num[lirs_pkg::RATE_W-1:0])
                   : prod_abs[lirs_pkg::DIV_W-1:0];
  assign div_den = cmd_i.div_sel_mod ? src_i : dst_i;

  lirs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Floor division of a signed product: round toward minus infinity
  assign q_mag = div_quot[lirs_pkg::DIFF_W-1:0];
  always_comb begin
    if (!prod_q[lirs_pkg::PROD_W-1]) begin
      q_floor = q_mag;
    end else if (div_rem != '0) begin
      q_floor = ~q_mag;
    end else begin
      q_floor = -q_mag;
    end
  end
  assign interp_sum = lirs_pkg::DIFF_W'(prev_q[c_q]) + q_floor;
  assign out_value  = is_tail ? cur_q[c_q] : interp_sum[lirs_pkg::SAMPLE_BITS-1:0];

  // Emission counters advance
  assign c_next     = (c_q == ch_last) ? '0 : c_q + 1'b1;
  assign frame_next = (c_q == ch_last) ? frame_q + 1'b1 : frame_q;
  assign ep_next    = ((c_q == ch_last) && !is_tail)
                      ? ep_q + lirs_pkg::PHASE_W'(src_i) : ep_q;

  // Frame store: shift current into previous at the start of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lirs_pkg::MAX_CHANNELS; i++) begin
        cur_q[i]  <= '0;
        prev_q[i] <= '0;
      end
      pos_q <= '0;
    end else if (cmd_i.load_sample) begin
      if ((pos_q == '0) && hp_q) begin
        for (int i = 0; i < lirs_pkg::MAX_CHANNELS; i++) begin
          prev_q[i] <= cur_q[i];
        end
      end
      cur_q[pos_q] <= sample_in_i;
      pos_q        <= frame_done ? '0 : pos_q + 1'b1;
    end
  end

  // Phase, walker and step bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q    <= 1'b0;
      ph_q    <= '0;
      final_q <= 1'b0;
      pw_q    <= '0;
      cnt_q   <= '0;
      n1_q    <= '0;
      n2_q    <= '0;
      over_q  <= 1'b0;
      frame_q <= '0;
      c_q     <= '0;
      ep_q    <= '0;
    end else begin
      if (cmd_i.step_init) begin
        pw_q    <= lirs_pkg::WALK_W'(ph_q);
        cnt_q   <= '0;
        n1_q    <= '0;
        n2_q    <= '0;
        over_q  <= 1'b0;
        final_q <= final_frame_i;
      end
      if (cmd_i.walk_step) begin
        pw_q  <= pw_q + lirs_pkg::WALK_W'(src_i);
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.span1_close) begin
        n1_q  <= cnt_q;
        cnt_q <= '0;
        if (below) begin
          over_q <= 1'b1;
        end else begin
          pw_q <= pw_q - lirs_pkg::WALK_W'(dst_i);
        end
      end
      if (cmd_i.mod_close) begin
        pw_q <= lirs_pkg::WALK_W'(src_i) - 1'b1 - lirs_pkg::WALK_W'(div_rem);
      end
      if (cmd_i.span2_close) begin
        n2_q <= cnt_q;
        if (below) begin
          over_q <= 1'b1;
        end
      end
      if (cmd_i.emit_init) begin
        frame_q <= '0;
        c_q     <= '0;
        ep_q    <= ph_q;
      end
      if (cmd_i.out_load) begin
        c_q     <= c_next;
        frame_q <= frame_next;
        ep_q    <= ep_next;
      end
      if (cmd_i.finish) begin
        ph_q <= final_q ? '0 : pw_q[lirs_pkg::PHASE_W-1:0];
        hp_q <= !final_q;
      end
    end
  end

  // Product register ahead of the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= diff * $signed({1'b0, ep_q});
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q      <= out_value;
      out_chan_q        <= c_q;
      out_run_last_q    <= is_last;
      out_region_last_q <= is_last && final_q;
      out_overrun_q     <= over_q;
    end
  end

  // Status
  always_comb begin
    stat_o            = '0;
    stat_o.frame_done = frame_done;
    stat_o.have_prev  = hp_q;
    stat_o.final_step = final_q;
    stat_o.walk_go    = below && (cnt_q < lirs_pkg::UPS_W'(lirs_pkg::MAX_UPSAMPLE));
    stat_o.walk_below = below;
    stat_o.div_done   = div_done;
    stat_o.total_zero = total == '0;
    stat_o.is_tail    = is_tail;
    stat_o.is_last    = is_last;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_sample_q;
  assign channel_index_o = out_chan_q;
  assign run_last_o      = out_run_last_q;
  assign region_last_o   = out_region_last_q;
  assign overrun_o       = out_overrun_q;

endmodule
